// ===== src/lrbs_pkg.sv =====
// ----------------------------------------------------------------------------
// lrbs_pkg
// Shared types and constants for the loop region block splitter.
// ----------------------------------------------------------------------------
package lrbs_pkg;

  localparam int LEN_W      = 13;  // block / segment length fields
  localparam int POS_OUT_W  = 48;  // positions on the ports
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  localparam int MAX_BLOCK_DEF     = 4096;
  localparam int MAX_SEGMENTS_DEF  = 64;
  localparam int POSITION_BITS_DEF = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOOP_START = 2'd0,
    CFG_LOOP_STOP  = 2'd1,
    CFG_LOOP_ON    = 2'd2,
    CFG_PLAYING    = 2'd3
  } cfg_reg_t;

  localparam logic KIND_BLOCK = 1'b0;
  localparam logic KIND_SEEK  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SEG
  } state_t;

  typedef struct packed {
    logic load;  // latch the accepted item
    logic step;  // emit one result into the output register
  } cmd_t;

  typedef struct packed {
    logic empty;     // block of zero samples: nothing to emit
    logic seg_last;  // the result being formed ends the item
    logic slot_free; // output register can take a result this cycle
  } sts_t;

endpackage

// ===== src/loop_region_block_splitter_top.sv =====
// An item is taken while the controller is idle and latched in the item
// registers; its first result is then registered in the output register,
// then one segment per cycle while out_stall is low. No new item is taken
// until the current item's last result (if any) is in the output register.
// Reset (synchronous, rst_n low): position and config registers cleared,
// no result pending, controller idle.
// ----------------------------------------------------------------------------
// loop_region_block_splitter_top
// Transport position keeper that splits audio blocks at loop boundaries.
// ----------------------------------------------------------------------------
module loop_region_block_splitter_top #(
  parameter int MAX_BLOCK     = lrbs_pkg::MAX_BLOCK_DEF,
  parameter int MAX_SEGMENTS  = lrbs_pkg::MAX_SEGMENTS_DEF,
  parameter int POSITION_BITS = lrbs_pkg::POSITION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lrbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrbs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_kind,
  input  logic [lrbs_pkg::LEN_W-1:0]      in_block_length,
  input  logic [lrbs_pkg::POS_OUT_W-1:0]  in_seek_position,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lrbs_pkg::POS_OUT_W-1:0]  out_segment_start,
  output logic [lrbs_pkg::LEN_W-1:0]      out_segment_length,
  output logic                            out_jumps_back,
  output logic                            out_segment_last,
  output logic                            out_truncated
);

  lrbs_pkg::cmd_t cmd;
  lrbs_pkg::sts_t sts;

  lrbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lrbs_dp #(
    .MAX_BLOCK     (MAX_BLOCK),
    .MAX_SEGMENTS  (MAX_SEGMENTS),
    .POSITION_BITS (POSITION_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_kind            (in_kind),
    .in_block_length    (in_block_length),
    .in_seek_position   (in_seek_position),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_segment_start  (out_segment_start),
    .out_segment_length (out_segment_length),
    .out_jumps_back     (out_jumps_back),
    .out_segment_last   (out_segment_last),
    .out_truncated      (out_truncated)
  );

`ifndef ASSERT_OFF
  // one item at a time: the controller closes the input after a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open straight after an accepted beat");

  // only a seek acknowledgment carries a zero length
  a_zero_len_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_segment_length != '0 || out_segment_last))
    else $error("zero-length segment that is not final");

  // a truncated segment closes its block
  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_truncated) |-> out_segment_last)
    else $error("truncated segment without segment_last");
`endif

endmodule

// ===== src/lrbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrbs_ctrl
// Controller: takes one item, then steps the datapath once per segment.
// ----------------------------------------------------------------------------
module lrbs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  lrbs_pkg::sts_t sts,
  output lrbs_pkg::cmd_t cmd
);

  lrbs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrbs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lrbs_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = lrbs_pkg::ST_SEG;
      end
      lrbs_pkg::ST_SEG: begin
        if (sts.empty) begin
          state_nxt = lrbs_pkg::ST_IDLE;
        end else if (sts.slot_free && sts.seg_last) begin
          state_nxt = lrbs_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    unique case (state_r)
      lrbs_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      lrbs_pkg::ST_SEG: begin
        cmd.step = sts.slot_free && !sts.empty;
      end
    endcase
  end

endmodule

// ===== src/lrbs_dp.sv =====
// ----------------------------------------------------------------------------
// lrbs_dp
// Datapath: config registers, sample position, segment arithmetic and the
// output register.
// ----------------------------------------------------------------------------
module lrbs_dp #(
  parameter int MAX_BLOCK     = lrbs_pkg::MAX_BLOCK_DEF,
  parameter int MAX_SEGMENTS  = lrbs_pkg::MAX_SEGMENTS_DEF,
  parameter int POSITION_BITS = lrbs_pkg::POSITION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lrbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrbs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_kind,
  input  logic [lrbs_pkg::LEN_W-1:0]      in_block_length,
  input  logic [lrbs_pkg::POS_OUT_W-1:0]  in_seek_position,
  input  lrbs_pkg::cmd_t                  cmd,
  output lrbs_pkg::sts_t                  sts,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lrbs_pkg::POS_OUT_W-1:0]  out_segment_start,
  output logic [lrbs_pkg::LEN_W-1:0]      out_segment_length,
  output logic                            out_jumps_back,
  output logic                            out_segment_last,
  output logic                            out_truncated
);

  localparam int LW   = lrbs_pkg::LEN_W;
  localparam int OW   = lrbs_pkg::POS_OUT_W;
  localparam int PW   = POSITION_BITS;
  // compare width: one bit above the wider of position and loop bounds
  localparam int CW   = ((PW > OW) ? PW : OW) + 1;
  localparam int CNTW = (MAX_SEGMENTS > 2) ? $clog2(MAX_SEGMENTS) : 1;
  localparam logic [CW-1:0]   PosMax  = {{(CW-PW){1'b0}}, {PW{1'b1}}};
  localparam logic [CNTW-1:0] LastCnt = CNTW'(MAX_SEGMENTS - 1);

  logic [OW-1:0]   loop_start_r, loop_stop_r;
  logic            loop_on_r, playing_r;
  logic [PW-1:0]   pos_r;
  logic            kind_r;
  logic [LW-1:0]   remain_r;
  logic [OW-1:0]   seek_r;
  logic [CNTW-1:0] cnt_r;

  logic            out_valid_r;
  logic [OW-1:0]   out_start_r;
  logic [LW-1:0]   out_len_r;
  logic            out_jump_r, out_last_r, out_trunc_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_start_r <= '0;
      loop_stop_r  <= '0;
      loop_on_r    <= 1'b0;
      playing_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (lrbs_pkg::cfg_reg_t'(cfg_index))
        lrbs_pkg::CFG_LOOP_START: loop_start_r <= cfg_data;
        lrbs_pkg::CFG_LOOP_STOP:  loop_stop_r  <= cfg_data;
        lrbs_pkg::CFG_LOOP_ON:    loop_on_r    <= cfg_data[0];
        lrbs_pkg::CFG_PLAYING:    playing_r    <= cfg_data[0];
      endcase
    end
  end

  // block length capped at MAX_BLOCK
  logic [LW-1:0] blk_len;
  always_comb begin
    if ({{(32-LW){1'b0}}, in_block_length} > 32'(MAX_BLOCK)) begin
      blk_len = LW'(MAX_BLOCK);
    end else begin
      blk_len = in_block_length;
    end
  end

  // segment arithmetic
  logic [CW-1:0] pos_w, start_w, stop_w, rem_w, seek_w, seek_sat;
  logic [CW-1:0] bound, gap, sum_w, next_w, next_sat;
  logic          looping, in_pre, in_loop, cut, jump;
  logic [LW-1:0] seg_len, rem_left;
  logic          at_limit, seg_last, seg_trunc;

  always_comb begin
    pos_w    = {{(CW-PW){1'b0}}, pos_r};
    start_w  = {{(CW-OW){1'b0}}, loop_start_r};
    stop_w   = {{(CW-OW){1'b0}}, loop_stop_r};
    rem_w    = {{(CW-LW){1'b0}}, remain_r};
    seek_w   = {{(CW-OW){1'b0}}, seek_r};
    seek_sat = (seek_w > PosMax) ? PosMax : seek_w;

    looping  = playing_r && loop_on_r && (loop_start_r < loop_stop_r);
    in_pre   = pos_w < start_w;
    in_loop  = !in_pre && (pos_w < stop_w);
    bound    = in_pre ? start_w : stop_w;
    gap      = bound - pos_w;
    // segment stops at the bound when the bound falls within the block
    cut      = looping && (in_pre || in_loop) && (gap <= rem_w);
    jump     = cut && in_loop;
    seg_len  = cut ? gap[LW-1:0] : remain_r;
    sum_w    = pos_w + rem_w;

    if (jump) begin
      next_w = start_w;
    end else if (cut) begin
      next_w = bound;
    end else begin
      next_w = sum_w;
    end
    next_sat = (next_w > PosMax) ? PosMax : next_w;

    rem_left  = remain_r - seg_len;
    at_limit  = (cnt_r == LastCnt);
    seg_last  = (rem_left == '0) || at_limit;
    seg_trunc = (rem_left != '0) && at_limit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cmd.step) begin
      if (kind_r == lrbs_pkg::KIND_SEEK) begin
        pos_r <= seek_sat[PW-1:0];
      end else if (playing_r) begin
        pos_r <= next_sat[PW-1:0];
      end
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_kind;
      remain_r <= blk_len;
      seek_r   <= in_seek_position;
      cnt_r    <= '0;
    end else if (cmd.step) begin
      remain_r <= rem_left;
      cnt_r    <= cnt_r + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      if (kind_r == lrbs_pkg::KIND_SEEK) begin
        out_start_r <= seek_sat[OW-1:0];
        out_len_r   <= '0;
        out_jump_r  <= 1'b0;
        out_last_r  <= 1'b1;
        out_trunc_r <= 1'b0;
      end else begin
        out_start_r <= pos_w[OW-1:0];
        out_len_r   <= seg_len;
        out_jump_r  <= jump;
        out_last_r  <= seg_last;
        out_trunc_r <= seg_trunc;
      end
    end
  end

  assign sts.empty     = (kind_r == lrbs_pkg::KIND_BLOCK) && (remain_r == '0);
  assign sts.seg_last  = (kind_r == lrbs_pkg::KIND_SEEK) || seg_last;
  assign sts.slot_free = !out_valid_r || !out_stall;

  assign out_valid          = out_valid_r;
  assign out_segment_start  = out_start_r;
  assign out_segment_length = out_len_r;
  assign out_jumps_back     = out_jump_r;
  assign out_segment_last   = out_last_r;
  assign out_truncated      = out_trunc_r;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the loop region block splitter: a directed table,
// then random transport settings with random blocks and seeks. Every result
// beat is compared with a table entry or a local model of the position and splits.
// ----------------------------------------------------------------------------
module tb_top;
  import lrbs_pkg::*;

  localparam logic [63:0] POS_TOP    = (64'd1 << POSITION_BITS_DEF) - 64'd1;
  localparam int          N_PHASES   = 10;
  localparam int          PHASE_ITEMS = 34;
  localparam int          HOLD_CYCLES = 400;
  localparam int          WDOG_LIMIT  = 3000;

  typedef struct packed {
    logic [POS_OUT_W-1:0] start;
    logic [LEN_W-1:0]     length;
    logic                 jump;
    logic                 last;
    logic                 trunc;
  } seg_t;

  typedef struct packed {
    logic                 kind;
    logic [LEN_W-1:0]     len;
    logic [POS_OUT_W-1:0] seek;
  } item_t;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_op_t;
  typedef enum logic [1:0] { CHK_MODEL, CHK_NONE, CHK_ONE } check_t;
  typedef enum logic [1:0] { RX_FREE, RX_COIN, RX_HEAVY, RX_TOGGLE } stall_mode_t;

  typedef struct packed {
    row_op_t              op;
    logic                 kind;
    logic [LEN_W-1:0]     len;
    logic [POS_OUT_W-1:0] arg;     // seek position or register data
    cfg_reg_t             reg_idx;
    check_t               chk;
    seg_t                 typed;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_kind = 1'b0;
  logic [LEN_W-1:0]      in_block_length = '0;
  logic [POS_OUT_W-1:0]  in_seek_position = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [POS_OUT_W-1:0]  out_segment_start;
  logic [LEN_W-1:0]      out_segment_length;
  logic                  out_jumps_back;
  logic                  out_segment_last;
  logic                  out_truncated;

  // local copy of the transport
  logic [63:0] play_pos = '0;
  logic [63:0] loop_first = '0;
  logic [63:0] loop_past = '0;
  logic        loop_en = 1'b0;
  logic        transport_run = 1'b0;

  seg_t pending_segments[$];
  int   err_count = 0;
  int   idle_cycles = 0;

  logic        hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_cnt = 0;
  int          mode_cnt = 0;
  stall_mode_t stall_mode = RX_FREE;

  loop_region_block_splitter_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_block_length    (in_block_length),
    .in_seek_position   (in_seek_position),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_segment_start  (out_segment_start),
    .out_segment_length (out_segment_length),
    .out_jumps_back     (out_jumps_back),
    .out_segment_last   (out_segment_last),
    .out_truncated      (out_truncated)
  );

  always #5 clk = ~clk;

  row_t dir_table [31] = '{
    '{ROW_ITEM, KIND_BLOCK, 13'd1,    48'd0, CFG_LOOP_START, CHK_ONE,
      '{48'd0, 13'd1, 1'b0, 1'b1, 1'b0}},
    '{ROW_ITEM, KIND_BLOCK, 13'd4096, 48'd0, CFG_LOOP_START, CHK_ONE,
      '{48'd0, 13'd4096, 1'b0, 1'b1, 1'b0}},
    // oversized block is cut to the maximum
    '{ROW_ITEM, KIND_BLOCK, 13'd8191, 48'd0, CFG_LOOP_START, CHK_ONE,
      '{48'd0, 13'd4096, 1'b0, 1'b1, 1'b0}},
    '{ROW_ITEM, KIND_BLOCK, 13'd0,    48'd0, CFG_LOOP_START, CHK_NONE, '0},
    '{ROW_ITEM, KIND_SEEK,  13'h1fff, 48'hFFFF_FFFF_FFFF, CFG_LOOP_START, CHK_ONE,
      '{48'hFFFF_FFFF_FFFF, 13'd0, 1'b0, 1'b1, 1'b0}},
    '{ROW_ITEM, KIND_BLOCK, 13'd5,    48'd0, CFG_LOOP_START, CHK_ONE,
      '{48'hFFFF_FFFF_FFFF, 13'd5, 1'b0, 1'b1, 1'b0}},
    '{ROW_ITEM, KIND_SEEK,  13'd0,    48'hAAAA_AAAA_AAAA, CFG_LOOP_START, CHK_ONE,
      '{48'hAAAA_AAAA_AAAA, 13'd0, 1'b0, 1'b1, 1'b0}},
    '{ROW_ITEM, KIND_SEEK,  13'd0,    48'h5555_5555_5555, CFG_LOOP_START, CHK_ONE,
      '{48'h5555_5555_5555, 13'd0, 1'b0, 1'b1, 1'b0}},
    '{ROW_CFG,  KIND_BLOCK, 13'd0,    48'd1, CFG_PLAYING, CHK_NONE, '0},
    '{ROW_ITEM, KIND_SEEK,  13'd0,    48'hFFFF_FFFF_FFF5, CFG_LOOP_START, CHK_ONE,
      '{48'hFFFF_FFFF_FFF5, 13'd0, 1'b0, 1'b1, 1'b0}},
    // position runs into the top and saturates
    '{ROW_ITEM, KIND_BLOCK, 13'd30,   48'd0, CFG_LOOP_START, CHK_ONE,
      '{48'hFFFF_FFFF_FFF5, 13'd30, 1'b0, 1'b1, 1'b0}},
    '{ROW_ITEM, KIND_BLOCK, 13'd5,    48'd0, CFG_LOOP_START, CHK_ONE,
      '{48'hFFFF_FFFF_FFFF, 13'd5, 1'b0, 1'b1, 1'b0}},
    '{ROW_CFG,  KIND_BLOCK, 13'd0,    48'd100, CFG_LOOP_START, CHK_NONE, '0},
    '{ROW_CFG,  KIND_BLOCK, 13'd0,    48'd200, CFG_LOOP_STOP,  CHK_NONE, '0},
    '{ROW_CFG,  KIND_BLOCK, 13'd0,    48'd1,   CFG_LOOP_ON,    CHK_NONE, '0},
    '{ROW_ITEM, KIND_SEEK,  13'd0,    48'd50, CFG_LOOP_START, CHK_ONE,
      '{48'd50, 13'd0, 1'b0, 1'b1, 1'b0}},
    '{ROW_ITEM, KIND_BLOCK, 13'd300,  48'd0, CFG_LOOP_START, CHK_MODEL, '0},
    '{ROW_ITEM, KIND_SEEK,  13'd0,    48'd150, CFG_LOOP_START, CHK_ONE,
      '{48'd150, 13'd0, 1'b0, 1'b1, 1'b0}},
    // block ends exactly on the loop stop
    '{ROW_ITEM, KIND_BLOCK, 13'd50,   48'd0, CFG_LOOP_START, CHK_MODEL, '0},
    '{ROW_CFG,  KIND_BLOCK, 13'd0,    48'd1000, CFG_LOOP_START, CHK_NONE, '0},
    '{ROW_CFG,  KIND_BLOCK, 13'd0,    48'd1001, CFG_LOOP_STOP,  CHK_NONE, '0},
    '{ROW_ITEM, KIND_SEEK,  13'd0,    48'd1000, CFG_LOOP_START, CHK_ONE,
      '{48'd1000, 13'd0, 1'b0, 1'b1, 1'b0}},
    // one-sample loop: runs out of segments
    '{ROW_ITEM, KIND_BLOCK, 13'd100,  48'd0, CFG_LOOP_START, CHK_MODEL, '0},
    '{ROW_CFG,  KIND_BLOCK, 13'd0,    48'd1000, CFG_LOOP_STOP, CHK_NONE, '0},
    '{ROW_ITEM, KIND_BLOCK, 13'd10,   48'd0, CFG_LOOP_START, CHK_MODEL, '0},
    '{ROW_CFG,  KIND_BLOCK, 13'd0,    48'hFFFF_FFFF_FFFF, CFG_LOOP_START, CHK_NONE, '0},
    '{ROW_ITEM, KIND_BLOCK, 13'd7,    48'd0, CFG_LOOP_START, CHK_MODEL, '0},
    '{ROW_CFG,  KIND_BLOCK, 13'd0,    48'd0, CFG_PLAYING, CHK_NONE, '0},
    '{ROW_ITEM, KIND_BLOCK, 13'd3,    48'd0, CFG_LOOP_START, CHK_MODEL, '0},
    '{ROW_CFG,  KIND_BLOCK, 13'd0,    48'd0, CFG_LOOP_ON, CHK_NONE, '0},
    '{ROW_ITEM, KIND_BLOCK, 13'd4096, 48'd0, CFG_LOOP_START, CHK_MODEL, '0}
  };

  function automatic logic [63:0] clamp_pos(input logic [63:0] v);
    return (v > POS_TOP) ? POS_TOP : v;
  endfunction

  // Splits one item into segments and moves the local position on.
  function automatic void split_item(input logic kind, input logic [LEN_W-1:0] len,
                                     input logic [POS_OUT_W-1:0] seek,
                                     ref seg_t segs[$]);
    logic [63:0] remain, pos, n, e;
    logic        looping, jump, last, trunc;
    int          nseg;
    segs.delete();
    if (kind == KIND_SEEK) begin
      play_pos = clamp_pos({16'd0, seek});
      segs.push_back('{play_pos[POS_OUT_W-1:0], '0, 1'b0, 1'b1, 1'b0});
      return;
    end
    remain = {51'd0, len};
    if (remain > MAX_BLOCK_DEF) remain = 64'(MAX_BLOCK_DEF);
    nseg = 0;
    while (remain != 0) begin
      pos = play_pos;
      n = remain;
      jump = 1'b0;
      last = 1'b0;
      trunc = 1'b0;
      looping = transport_run && loop_en && (loop_first < loop_past);
      if (looping) begin
        e = pos + remain;
        if (pos < loop_first) begin
          n = ((e < loop_first) ? e : loop_first) - pos;
        end else if (pos < loop_past) begin
          n = ((e < loop_past) ? e : loop_past) - pos;
          jump = (pos + n == loop_past);
        end
      end
      if (transport_run) play_pos = jump ? clamp_pos(loop_first) : clamp_pos(pos + n);
      remain -= n;
      nseg++;
      if (remain == 0) begin
        last = 1'b1;
      end else if (nseg >= MAX_SEGMENTS_DEF) begin
        last = 1'b1;
        trunc = 1'b1;
      end
      segs.push_back('{pos[POS_OUT_W-1:0], n[LEN_W-1:0], jump, last, trunc});
      if (last) break;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch %s: got %0h, want %0h", $realtime, what, got, want);
    err_count++;
  endtask

  // ---- result checker
  always @(posedge clk) begin : check_out
    seg_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_segments.size() == 0) begin
        report_mismatch("unexpected beat", 64'(out_segment_start), 64'd0);
      end else begin
        want = pending_segments.pop_front();
        if (out_segment_start !== want.start)
          report_mismatch("segment_start", 64'(out_segment_start), 64'(want.start));
        if (out_segment_length !== want.length)
          report_mismatch("segment_length", 64'(out_segment_length), 64'(want.length));
        if (out_jumps_back !== want.jump)
          report_mismatch("jumps_back", 64'(out_jumps_back), 64'(want.jump));
        if (out_segment_last !== want.last)
          report_mismatch("segment_last", 64'(out_segment_last), 64'(want.last));
        if (out_truncated !== want.trunc)
          report_mismatch("truncated", 64'(out_truncated), 64'(want.trunc));
      end
    end
  end

  // ---- receiver stall pattern, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (mode_cnt == 0) begin
      out_stall <= 1'b0;
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      mode_cnt <= $urandom_range(20, 120);
    end else begin
      mode_cnt <= mode_cnt - 1;
      case (stall_mode)
        RX_FREE:   out_stall <= 1'b0;
        RX_COIN:   out_stall <= 1'($urandom_range(0, 1));
        RX_HEAVY:  out_stall <= ($urandom_range(0, 9) < 8);
        default:   out_stall <= ~out_stall;
      endcase
    end
  end

  // ---- watchdog: cycles with no beat moving anywhere
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("[%0t] watchdog expired, %0d segments outstanding", $realtime,
               pending_segments.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drop valid, drain outstanding results, then allow for a trailing empty block.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_segments.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LOOP_START: loop_first = {16'd0, val};
      CFG_LOOP_STOP:  loop_past = {16'd0, val};
      CFG_LOOP_ON:    loop_en = val[0];
      default:        transport_run = val[0];
    endcase
    @(posedge clk);
  endtask

  task automatic set_transport(input logic [47:0] first, input logic [47:0] past,
                               input logic on, input logic run);
    settle();
    write_reg(CFG_LOOP_START, first);
    write_reg(CFG_LOOP_STOP, past);
    write_reg(CFG_LOOP_ON, {47'd0, on});
    write_reg(CFG_PLAYING, {47'd0, run});
  endtask

  task automatic offer_item(input logic kind, input logic [LEN_W-1:0] len,
                            input logic [POS_OUT_W-1:0] arg, input check_t chk,
                            input seg_t typed);
    seg_t segs[$];
    in_kind <= kind;
    in_block_length <= len;
    in_seek_position <= arg;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    split_item(kind, len, arg, segs);
    case (chk)
      CHK_MODEL: foreach (segs[i]) pending_segments.push_back(segs[i]);
      CHK_ONE:   pending_segments.push_back(typed);
      default:   ;
    endcase
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  // Blocks mostly short, seeks mostly near the loop so that splits happen.
  function automatic item_t pick_item();
    item_t it;
    int    r;
    it.kind = ($urandom_range(0, 99) < 15) ? KIND_SEEK : KIND_BLOCK;
    it.len = LEN_W'($urandom_range(0, 8191));
    it.seek = rand48();
    if (it.kind == KIND_SEEK) begin
      r = $urandom_range(0, 9);
      if (r < 5)       it.seek = loop_first[47:0] - $urandom_range(0, 40);
      else if (r < 7)  it.seek = loop_first[47:0] + $urandom_range(0, 60);
      else if (r == 8) it.seek = POS_TOP[47:0] - $urandom_range(0, 50);
      else if (r == 9) it.seek = loop_past[47:0] - $urandom_range(0, 5);
    end else begin
      r = $urandom_range(0, 19);
      if (r == 0)      it.len = '0;
      else if (r == 1) it.len = LEN_W'($urandom_range(4097, 8191));
      else if (r == 2) it.len = 13'd4096;
      else if (r < 5)  it.len = LEN_W'($urandom_range(301, 4095));
      else             it.len = LEN_W'($urandom_range(1, 300));
    end
    return it;
  endfunction

  task automatic idle_gap(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  initial begin : stimulus
    item_t       it;
    row_t        r;
    logic [47:0] first, past;
    logic        on, run, gappy;
    int          burst_left, pick;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[i]) begin
      r = dir_table[i];
      if (r.op == ROW_CFG) begin
        settle();
        write_reg(r.reg_idx, r.arg);
      end else begin
        offer_item(r.kind, r.len, r.arg, r.chk, r.typed);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      on = ($urandom_range(0, 5) != 0);
      run = ($urandom_range(0, 5) != 0);
      pick = $urandom_range(0, 2);
      first = (pick == 0) ? $urandom_range(0, 2000) :
              (pick == 1) ? rand48() : POS_TOP[47:0] - $urandom_range(0, 3000);
      pick = $urandom_range(0, 9);
      if (pick < 6)       past = first + $urandom_range(1, 20);
      else if (pick < 8)  past = first + $urandom_range(21, 2000);
      else if (pick == 8) past = first;
      else                past = first - $urandom_range(1, 50);
      case (ph)
        0: begin first = '0; past = POS_TOP[47:0]; on = 1'b1; run = 1'b1; end
        1: begin
          first = POS_TOP[47:0] - 20; past = POS_TOP[47:0]; on = 1'b1; run = 1'b1;
        end
        2: begin past = first; run = 1'b1; end
        3: begin on = 1'b1; run = 1'b0; end
        default: ;
      endcase
      set_transport(first, past, on, run);
      gappy = (ph != 1) && ($urandom_range(0, 3) != 0);
      burst_left = $urandom_range(1, 12);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // the long receiver hold-off lands while beats keep coming
        if (ph == 1 && k == 3) hold_req <= 1'b1;
        it = pick_item();
        offer_item(it.kind, it.len, it.seek, CHK_MODEL, '0);
        burst_left--;
        if (gappy && burst_left == 0) begin
          idle_gap($urandom_range(1, 10));
          burst_left = $urandom_range(1, 12);
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_segments.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
